>>> sv/usd_pkg.sv
// shared types, request codes and constants for the usb standard request decoder
`default_nettype none
package usd_pkg;

  // default depth of the descriptor table
  localparam int DEF_TABLE_SLOTS = 8;

  // field widths
  localparam int SLOT_NUM_W = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  // endpoint 0 actions
  typedef enum logic [1:0] {
    ACT_ACK   = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_STALL = 2'd2
  } action_t;

  // reply data sources
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_REPLY = 3'd1,
    SRC_SLOT  = 3'd2,
    SRC_WCID  = 3'd3,
    SRC_URL   = 3'd4
  } source_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MSFT_CODE   = 2'd0,
    CFG_WEBUSB_CODE = 2'd1,
    CFG_WCID_LEN    = 2'd2,
    CFG_URL_LEN     = 2'd3
  } cfg_reg_t;

  // bRequest and bmRequestType pairs, request code in the high byte
  localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] REQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] REQ_GET_DEV_STATUS = 16'h0080;
  localparam logic [15:0] REQ_GET_EP_STATUS  = 16'h0082;
  localparam logic [15:0] REQ_CLEAR_EP_FEAT  = 16'h0102;
  localparam logic [15:0] REQ_SET_EP_FEAT    = 16'h0302;
  localparam logic [15:0] REQ_GET_DESC_DEV   = 16'h0680;
  localparam logic [15:0] REQ_GET_DESC_IF    = 16'h0681;
  localparam logic [15:0] REQ_SET_INTERFACE  = 16'h0b01;

  // vendor request fields
  localparam logic [7:0]  VENDOR_TYPE_DEV = 8'hc0;
  localparam logic [7:0]  VENDOR_TYPE_IF  = 8'hc1;
  localparam logic [15:0] WCID_INDEX      = 16'h0004;
  localparam logic [15:0] URL_INDEX       = 16'h0002;
  localparam logic [15:0] URL_VALUE       = 16'h0001;

  // fixed reply lengths
  localparam logic [15:0] LEN_CONFIG = 16'd1;
  localparam logic [15:0] LEN_STATUS = 16'd2;

  // configuration register reset values
  localparam logic [7:0] RST_MSFT_CODE   = 8'd32;
  localparam logic [7:0] RST_WEBUSB_CODE = 8'd33;
  localparam logic [7:0] RST_WCID_LEN    = 8'd40;
  localparam logic [7:0] RST_URL_LEN     = 8'd0;

  // descriptor table search result
  typedef struct packed {
    logic                  hit;
    logic [SLOT_NUM_W-1:0] slot;
    logic [15:0]           length;
  } lookup_t;

endpackage : usd_pkg
`default_nettype wire

>>> sv/usd_desc_table.sv
// descriptor table: slot storage, slot loads and parallel key search
`default_nettype none
module usd_desc_table
  import usd_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [SLOT_NUM_W-1:0] wr_slot,
  input  wire logic [15:0]           wr_key,
  input  wire logic [15:0]           wr_length,
  input  wire logic                  wr_used,
  input  wire logic [15:0]           lookup_key,
  output lookup_t                    lookup
);

  logic [15:0]            key_r [TABLE_SLOTS];
  logic [15:0]            len_r [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] used_r;

  // used bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (32'(wr_slot) == i) begin
          used_r[i] <= wr_used;
        end
      end
    end
  end

  // key and length payload, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (32'(wr_slot) == i) begin
          key_r[i] <= wr_key;
          len_r[i] <= wr_length;
        end
      end
    end
  end

  // lowest match wins, search ends at the first empty slot
  always_comb begin
    logic alive;
    alive  = 1'b1;
    lookup = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (alive && !lookup.hit) begin
        if (!used_r[i]) begin
          alive = 1'b0;
        end else if (key_r[i] == lookup_key) begin
          lookup.hit    = 1'b1;
          lookup.slot   = SLOT_NUM_W'(i);
          lookup.length = len_r[i];
        end
      end
    end
  end

endmodule : usd_desc_table
`default_nettype wire

>>> sv/usb_standard_request_decoder_unit.sv
// usb standard request decoder: input register, request decode, result register
// a setup word passes the input register and then the result register
// throughput: one word per cycle unless out_tready stalls; load words update
// the table and give no result; the input register and the result register
// stall together with out_tready; reset clears the stored configuration byte,
// the table used bits and the vendor codes and lengths to their defaults
`default_nettype none
module usb_standard_request_decoder_unit
  import usd_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request words
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // request_type, request_code, setup_value, setup_index, setup_length,
  // slot_number, slot_key, slot_length, slot_used, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // set for a table load word, clear for a setup word
  input  wire logic                  in_tuser,
  // result words
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // action, direction_in, address_write, device_address, data_source,
  // descriptor_slot, reply_byte, send_length, zero pad
  output      logic [OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  // configuration registers
  logic [7:0] msft_code_r, webusb_code_r, wcid_len_r, url_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msft_code_r   <= RST_MSFT_CODE;
      webusb_code_r <= RST_WEBUSB_CODE;
      wcid_len_r    <= RST_WCID_LEN;
      url_len_r     <= RST_URL_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MSFT_CODE:   msft_code_r   <= cfg_data;
        CFG_WEBUSB_CODE: webusb_code_r <= cfg_data;
        CFG_WCID_LEN:    wcid_len_r    <= cfg_data;
        CFG_URL_LEN:     url_len_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r, out_valid_r;
  logic s2_take, s1_fire, in_fire;

  assign s2_take   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_take;
  assign in_tready = !s1_valid_r || s2_take;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  logic                  s1_load_r;
  logic [7:0]            s1_rtype_r, s1_rcode_r;
  logic [15:0]           s1_value_r, s1_index_r, s1_wlen_r;
  logic [SLOT_NUM_W-1:0] s1_slot_r;
  logic [15:0]           s1_key_r, s1_slen_r;
  logic                  s1_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_load_r  <= in_tuser;
      s1_rtype_r <= in_tdata[7:0];
      s1_rcode_r <= in_tdata[15:8];
      s1_value_r <= in_tdata[31:16];
      s1_index_r <= in_tdata[47:32];
      s1_wlen_r  <= in_tdata[63:48];
      s1_slot_r  <= in_tdata[66:64];
      s1_key_r   <= in_tdata[82:67];
      s1_slen_r  <= in_tdata[98:83];
      s1_used_r  <= in_tdata[99];
    end
  end

  // descriptor table
  lookup_t lookup;

  usd_desc_table #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (s1_fire && s1_load_r),
    .wr_slot    (s1_slot_r),
    .wr_key     (s1_key_r),
    .wr_length  (s1_slen_r),
    .wr_used    (s1_used_r),
    .lookup_key (s1_value_r),
    .lookup     (lookup)
  );

  // current configuration byte
  logic [7:0] config_r;
  logic       set_config;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      config_r <= '0;
    end else if (s1_fire && !s1_load_r && set_config) begin
      config_r <= s1_value_r[7:0];
    end
  end

  // request decode
  logic [15:0]           combo;
  logic                  stall, addr_wr;
  logic [6:0]            addr;
  source_t               src;
  logic [SLOT_NUM_W-1:0] slot_sel;
  logic [7:0]            reply;
  logic [15:0]           len;
  logic                  is_vendor_type;

  assign combo          = {s1_rcode_r, s1_rtype_r};
  assign is_vendor_type = (s1_rtype_r == VENDOR_TYPE_DEV) || (s1_rtype_r == VENDOR_TYPE_IF);

  always_comb begin
    stall      = 1'b0;
    addr_wr    = 1'b0;
    addr       = '0;
    src        = SRC_NONE;
    slot_sel   = '0;
    reply      = '0;
    len        = '0;
    set_config = 1'b0;
    unique case (combo)
      REQ_SET_ADDRESS: begin
        addr_wr = 1'b1;
        addr    = s1_value_r[6:0];
      end
      REQ_SET_INTERFACE: ;
      REQ_SET_CONFIG: set_config = 1'b1;
      REQ_GET_CONFIG: begin
        src   = SRC_REPLY;
        reply = config_r;
        len   = LEN_CONFIG;
      end
      REQ_GET_DEV_STATUS: begin
        src = SRC_REPLY;
        len = LEN_STATUS;
      end
      REQ_GET_EP_STATUS: begin
        if (s1_index_r != '0) begin
          stall = 1'b1;
        end else begin
          src = SRC_REPLY;
          len = LEN_STATUS;
        end
      end
      REQ_CLEAR_EP_FEAT, REQ_SET_EP_FEAT: begin
        stall = (s1_index_r != '0) || (s1_value_r != '0);
      end
      REQ_GET_DESC_DEV, REQ_GET_DESC_IF: begin
        if (lookup.hit) begin
          src      = SRC_SLOT;
          slot_sel = lookup.slot;
          len      = lookup.length;
        end else begin
          stall = 1'b1;
        end
      end
      default: begin
        // vendor requests, compatible id first when the codes are equal
        if (s1_rcode_r == msft_code_r && is_vendor_type) begin
          if (s1_index_r == WCID_INDEX) begin
            src = SRC_WCID;
            len = {8'd0, wcid_len_r};
          end else begin
            stall = 1'b1;
          end
        end else if (s1_rcode_r == webusb_code_r && s1_rtype_r == VENDOR_TYPE_DEV) begin
          if (s1_index_r == URL_INDEX && s1_value_r == URL_VALUE) begin
            src = SRC_URL;
            len = {8'd0, url_len_r};
          end else begin
            stall = 1'b1;
          end
        end else begin
          stall = 1'b1;
        end
      end
    endcase
  end

  // final action and length clip
  action_t               act_nxt;
  source_t               src_nxt;
  logic [SLOT_NUM_W-1:0] slot_nxt;
  logic [7:0]            reply_nxt;
  logic [15:0]           len_nxt;

  always_comb begin
    act_nxt   = ACT_ACK;
    src_nxt   = SRC_NONE;
    slot_nxt  = '0;
    reply_nxt = '0;
    len_nxt   = '0;
    if (stall) begin
      act_nxt = ACT_STALL;
    end else if (src != SRC_NONE && len != '0) begin
      act_nxt   = ACT_SEND;
      src_nxt   = src;
      slot_nxt  = slot_sel;
      reply_nxt = reply;
      len_nxt   = (len > s1_wlen_r) ? s1_wlen_r : len;
    end
  end

  // result register
  action_t               act_r;
  logic                  dir_r, addr_wr_r;
  logic [6:0]            addr_r;
  source_t               src_r;
  logic [SLOT_NUM_W-1:0] slot_r;
  logic [7:0]            reply_r;
  logic [15:0]           len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r && !s1_load_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_load_r) begin
      act_r     <= act_nxt;
      dir_r     <= s1_rtype_r[7];
      addr_wr_r <= addr_wr;
      addr_r    <= addr;
      src_r     <= src_nxt;
      slot_r    <= slot_nxt;
      reply_r   <= reply_nxt;
      len_r     <= len_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, len_r, reply_r, slot_r, src_r, addr_r, addr_wr_r, dir_r, act_r};

endmodule : usb_standard_request_decoder_unit
`default_nettype wire

>>> dv/usb_standard_request_decoder_unit_tb.sv
// testbench for the usb request decoder: directed and random words checked by a built-in model
`timescale 1ns / 1ps

module usb_standard_request_decoder_unit_tb
  import usd_pkg::*;
();

  localparam int SLOTS       = DEF_TABLE_SLOTS;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 30;

  // input word fields, request_type in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic        slot_used;
    logic [15:0] slot_length;
    logic [15:0] slot_key;
    logic [2:0]  slot_number;
    logic [15:0] setup_length;
    logic [15:0] setup_index;
    logic [15:0] setup_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
  } request_word_t;

  // endpoint 0 decision fields, action in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] send_length;
    logic [7:0]  reply_byte;
    logic [2:0]  descriptor_slot;
    source_t     data_source;
    logic [6:0]  device_address;
    logic        address_write;
    logic        direction_in;
    action_t     action;
  } ep0_decision_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // request_type, request_code, setup_value, setup_index, setup_length,
  // slot_number, slot_key, slot_length, slot_used, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // set for a table load word, clear for a setup word
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // action, direction_in, address_write, device_address, data_source,
  // descriptor_slot, reply_byte, send_length, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [7:0]            cfg_data = '0;

  // decision model state
  logic [7:0]    vendor_wcid_code = RST_MSFT_CODE;
  logic [7:0]    vendor_url_code  = RST_WEBUSB_CODE;
  logic [7:0]    wcid_len         = RST_WCID_LEN;
  logic [7:0]    url_len          = RST_URL_LEN;
  logic [7:0]    model_config_byte = '0;
  logic [15:0]   desc_key [SLOTS];
  logic [15:0]   desc_len [SLOTS];
  bit            desc_used [SLOTS];
  ep0_decision_t ep0_decisions_due [$];

  // traffic shaping
  int tx_gap_max   = 0;
  int tx_burst_left = 1;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  // bookkeeping
  int unsigned   mismatch_count = 0;
  int unsigned   n_setup = 0;
  int unsigned   n_load = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_cfg = 0;
  int unsigned   quiet_cycles = 0;
  ep0_decision_t seen_word;
  ep0_decision_t due_word;

  usb_standard_request_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mismatch reporting, printing capped so a broken block cannot flood the log
  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp);
    if (got !== exp)
      report_error($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, exp));
  endtask

  // table search for descriptor reads: stops at first empty slot, lowest hit wins
  task automatic decide_ep0(input bit is_load, input request_word_t w);
    ep0_decision_t d;
    logic [15:0]   req;
    logic [15:0]   data_len;
    bit            hit;
    int            i;
    if (is_load) begin
      n_load++;
      if (int'(w.slot_number) < SLOTS) begin
        desc_key[w.slot_number]  = w.slot_key;
        desc_len[w.slot_number]  = w.slot_length;
        desc_used[w.slot_number] = w.slot_used;
      end
    end else begin
      n_setup++;
      d = '0;
      data_len = '0;
      hit = 1'b0;
      d.direction_in = w.request_type[7];
      req = {w.request_code, w.request_type};
      case (req)
        REQ_SET_ADDRESS: begin
          d.address_write = 1'b1;
          d.device_address = w.setup_value[6:0];
        end
        REQ_SET_INTERFACE: ;
        REQ_SET_CONFIG: model_config_byte = w.setup_value[7:0];
        REQ_GET_CONFIG: begin
          d.data_source = SRC_REPLY;
          d.reply_byte = model_config_byte;
          data_len = LEN_CONFIG;
        end
        REQ_GET_DEV_STATUS: begin
          d.data_source = SRC_REPLY;
          data_len = LEN_STATUS;
        end
        REQ_GET_EP_STATUS: begin
          if (w.setup_index != 0) d.action = ACT_STALL;
          else begin
            d.data_source = SRC_REPLY;
            data_len = LEN_STATUS;
          end
        end
        REQ_CLEAR_EP_FEAT, REQ_SET_EP_FEAT: begin
          if (w.setup_index != 0 || w.setup_value != 0) d.action = ACT_STALL;
        end
        REQ_GET_DESC_DEV, REQ_GET_DESC_IF: begin
          for (i = 0; i < SLOTS && desc_used[i] && !hit; i++) begin
            if (desc_key[i] == w.setup_value) begin
              hit = 1'b1;
              d.data_source = SRC_SLOT;
              d.descriptor_slot = 3'(i);
              data_len = desc_len[i];
            end
          end
          if (!hit) d.action = ACT_STALL;
        end
        default: begin
          // compatible id request wins when both vendor codes are equal
          if (w.request_code == vendor_wcid_code &&
              (w.request_type == VENDOR_TYPE_DEV || w.request_type == VENDOR_TYPE_IF)) begin
            if (w.setup_index == WCID_INDEX) begin
              d.data_source = SRC_WCID;
              data_len = 16'(wcid_len);
            end else d.action = ACT_STALL;
          end else if (w.request_code == vendor_url_code &&
                       w.request_type == VENDOR_TYPE_DEV) begin
            if (w.setup_index == URL_INDEX && w.setup_value == URL_VALUE) begin
              d.data_source = SRC_URL;
              data_len = 16'(url_len);
            end else d.action = ACT_STALL;
          end else d.action = ACT_STALL;
        end
      endcase
      // zero-length data turns into a plain ack; length clipped to wLength
      if (d.action != ACT_STALL && d.data_source != SRC_NONE && data_len != 0) begin
        d.action = ACT_SEND;
        d.send_length = (data_len > w.setup_length) ? w.setup_length : data_len;
      end else begin
        d.data_source = SRC_NONE;
        d.descriptor_slot = '0;
        d.reply_byte = '0;
        d.send_length = '0;
      end
      ep0_decisions_due.push_back(d);
    end
  endtask

  // offer one word, wait for the handshake, then maybe open a gap
  task automatic send_word(input bit is_load, input request_word_t w);
    in_tvalid <= 1'b1;
    in_tuser <= is_load;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decide_ep0(is_load, w);
    if (tx_gap_max != 0) begin
      if (tx_burst_left <= 1) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
        tx_burst_left = $urandom_range(1, 12);
      end else tx_burst_left--;
    end
  endtask

  task automatic send_setup(input logic [15:0] req, input logic [15:0] value,
                            input logic [15:0] index, input logic [15:0] wlen);
    request_word_t w;
    w = '0;
    {w.request_code, w.request_type} = req;
    w.setup_value = value;
    w.setup_index = index;
    w.setup_length = wlen;
    send_word(1'b0, w);
  endtask

  task automatic load_slot(input logic [2:0] slot, input logic [15:0] key,
                           input logic [15:0] len, input logic used);
    request_word_t w;
    w = '0;
    w.slot_number = slot;
    w.slot_key = key;
    w.slot_length = len;
    w.slot_used = used;
    send_word(1'b1, w);
  endtask

  task automatic wait_results();
    while (ep0_decisions_due.size() != 0) @(posedge clk);
  endtask

  // stop sending and let load words finish too, they give no result
  task automatic go_idle();
    in_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    case (idx)
      CFG_MSFT_CODE:   vendor_wcid_code = v;
      CFG_WEBUSB_CODE: vendor_url_code = v;
      CFG_WCID_LEN:    wcid_len = v;
      CFG_URL_LEN:     url_len = v;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] wcid_code, input logic [7:0] url_code,
                              input logic [7:0] wcid_bytes, input logic [7:0] url_bytes);
    go_idle();
    write_reg(CFG_MSFT_CODE, wcid_code);
    write_reg(CFG_WEBUSB_CODE, url_code);
    write_reg(CFG_WCID_LEN, wcid_bytes);
    write_reg(CFG_URL_LEN, url_bytes);
    cfg_valid <= 1'b0;
  endtask

  // random field helpers
  function automatic logic [15:0] random_wide();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_key();
    return {8'($urandom_range(1, 3)), 8'($urandom_range(0, 2))};
  endfunction

  function automatic logic [15:0] standard_request();
    case ($urandom_range(0, 9))
      0:       return REQ_SET_ADDRESS;
      1:       return REQ_SET_CONFIG;
      2:       return REQ_GET_CONFIG;
      3:       return REQ_GET_DEV_STATUS;
      4:       return REQ_GET_EP_STATUS;
      5:       return REQ_CLEAR_EP_FEAT;
      6:       return REQ_SET_EP_FEAT;
      7:       return REQ_GET_DESC_DEV;
      8:       return REQ_GET_DESC_IF;
      default: return REQ_SET_INTERFACE;
    endcase
  endfunction

  // mostly well-formed standard and vendor requests, the rest noise
  function automatic request_word_t random_setup();
    request_word_t w;
    int            pick;
    w = '0;
    w.slot_number = 3'($urandom);
    w.slot_key = 16'($urandom);
    w.slot_length = 16'($urandom);
    w.slot_used = 1'($urandom);
    w.setup_value = random_wide();
    w.setup_index = ($urandom_range(0, 2) == 0) ? random_wide() : 16'h0000;
    w.setup_length = random_wide();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      {w.request_code, w.request_type} = standard_request();
      if (w.request_code == REQ_GET_DESC_DEV[15:8] && $urandom_range(0, 9) < 7)
        w.setup_value = random_key();
      if ((w.request_code == REQ_CLEAR_EP_FEAT[15:8] || w.request_code == REQ_SET_EP_FEAT[15:8])
          && $urandom_range(0, 9) < 6)
        w.setup_value = 16'h0000;
    end else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0:       w.request_code = vendor_wcid_code;
        1:       w.request_code = vendor_url_code;
        default: w.request_code = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0, 1:    w.request_type = VENDOR_TYPE_DEV;
        2:       w.request_type = VENDOR_TYPE_IF;
        default: w.request_type = 8'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       w.setup_index = WCID_INDEX;
        1:       w.setup_index = URL_INDEX;
        default: w.setup_index = random_wide();
      endcase
      if ($urandom_range(0, 1) == 0) w.setup_value = URL_VALUE;
    end else begin
      w.request_code = 8'($urandom);
      w.request_type = 8'($urandom);
    end
    return w;
  endfunction

  function automatic request_word_t random_load();
    request_word_t w;
    w = '0;
    w.request_type = 8'($urandom);
    w.request_code = 8'($urandom);
    w.setup_value = 16'($urandom);
    w.setup_index = 16'($urandom);
    w.setup_length = 16'($urandom);
    w.slot_number = 3'($urandom);
    w.slot_key = ($urandom_range(0, 99) < 85) ? random_key() : 16'($urandom);
    w.slot_length = random_wide();
    w.slot_used = ($urandom_range(0, 99) < 85);
    return w;
  endfunction

  task automatic send_random_word();
    if ($urandom_range(0, 99) < 15) send_word(1'b1, random_load());
    else send_word(1'b0, random_setup());
  endtask

  // reset defaults: empty table, zero configuration, default vendor codes
  task automatic test_reset_state();
    send_setup(REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'hffff);
    send_setup(REQ_GET_DESC_DEV, 16'h0100, 16'h0000, 16'hffff);
    send_setup({RST_MSFT_CODE, VENDOR_TYPE_DEV}, 16'h0000, WCID_INDEX, 16'hffff);
    send_setup({RST_WEBUSB_CODE, VENDOR_TYPE_DEV}, URL_VALUE, URL_INDEX, 16'hffff);
  endtask

  task automatic test_standard_requests();
    send_setup(REQ_SET_ADDRESS, 16'hffff, 16'h0000, 16'h0000);
    send_setup(REQ_SET_INTERFACE, 16'h0001, 16'h0001, 16'h0000);
    send_setup(REQ_SET_CONFIG, 16'habff, 16'h0000, 16'h0000);
    send_setup(REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0000);
    send_setup(REQ_GET_DEV_STATUS, 16'h0000, 16'h0000, 16'h0001);
    send_setup(REQ_GET_EP_STATUS, 16'h0000, 16'h0000, 16'h0040);
    send_setup(REQ_GET_EP_STATUS, 16'h0000, 16'hffff, 16'h0040);
    send_setup(REQ_CLEAR_EP_FEAT, 16'h0000, 16'h0000, 16'h0000);
    send_setup(REQ_CLEAR_EP_FEAT, 16'hffff, 16'h0000, 16'h0000);
    send_setup(REQ_SET_EP_FEAT, 16'h0000, 16'h0001, 16'h0000);
    send_setup(16'hffff, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // duplicate key, zero length, entry past the first empty slot, no match
  task automatic test_descriptor_table();
    load_slot(3'd0, 16'h0100, 16'd18, 1'b1);
    load_slot(3'd1, 16'h0200, 16'd0, 1'b1);
    load_slot(3'd2, 16'h0302, 16'hffff, 1'b1);
    load_slot(3'd3, 16'h0100, 16'd9, 1'b1);
    load_slot(3'd4, 16'h0400, 16'd7, 1'b0);
    load_slot(3'd5, 16'h0400, 16'd5, 1'b1);
    send_setup(REQ_GET_DESC_DEV, 16'h0100, 16'h0000, 16'h0004);
    send_setup(REQ_GET_DESC_IF, 16'h0200, 16'h0000, 16'hffff);
    send_setup(REQ_GET_DESC_DEV, 16'h0302, 16'h0000, 16'hffff);
    send_setup(REQ_GET_DESC_IF, 16'h0400, 16'h0000, 16'hffff);
  endtask

  // equal vendor codes, interface recipient, wrong index or value, zero length
  task automatic test_vendor_requests();
    apply_config(8'd7, 8'd7, 8'hff, 8'd200);
    send_setup({8'd7, VENDOR_TYPE_IF}, 16'h0000, WCID_INDEX, 16'h00ff);
    send_setup({8'd7, VENDOR_TYPE_DEV}, URL_VALUE, URL_INDEX, 16'hffff);
    apply_config(8'd9, 8'd10, 8'd0, 8'hff);
    send_setup({8'd9, VENDOR_TYPE_DEV}, 16'h0000, WCID_INDEX, 16'hffff);
    send_setup({8'd10, VENDOR_TYPE_DEV}, URL_VALUE, URL_INDEX, 16'h0010);
    send_setup({8'd10, VENDOR_TYPE_IF}, URL_VALUE, URL_INDEX, 16'h0010);
    send_setup({8'd10, VENDOR_TYPE_DEV}, 16'h0002, URL_INDEX, 16'h0010);
  endtask

  // random words under several register settings and idling patterns
  task automatic test_random_phases();
    int         phase;
    logic [7:0] shared_code;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          apply_config(RST_MSFT_CODE, RST_WEBUSB_CODE, RST_WCID_LEN, RST_URL_LEN);
          tx_gap_max = 0;
          rx_stall_pct = 0;
        end
        1: begin
          apply_config(8'h00, 8'h00, 8'h00, 8'hff);
          tx_gap_max = 3;
          rx_stall_pct = 30;
        end
        2: begin
          apply_config(8'hff, 8'hfe, 8'hff, 8'h01);
          tx_gap_max = 8;
          rx_stall_pct = 10;
        end
        3: begin
          // vendor codes that equal standard request codes
          apply_config(REQ_GET_DESC_DEV[15:8], REQ_SET_ADDRESS[15:8], 8'h01, 8'h00);
          tx_gap_max = 1;
          rx_stall_pct = 60;
        end
        4: begin
          apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          tx_gap_max = 5;
          rx_stall_pct = 0;
        end
        default: begin
          shared_code = 8'($urandom);
          apply_config(shared_code, shared_code, 8'($urandom), 8'($urandom));
          tx_gap_max = 0;
          rx_stall_pct = 50;
        end
      endcase
      repeat (90) send_random_word();
    end
  endtask

  // long receiver hold while words keep coming, then a full drain mid-stream
  task automatic test_backpressure();
    go_idle();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    rx_hold_left = 300;
    repeat (24) send_word(1'b0, random_setup());
    in_tvalid <= 1'b0;
    wait_results();
    tx_gap_max = 4;
    rx_stall_pct = 20;
    repeat (16) send_random_word();
    go_idle();
  endtask

  // receiver: long holds on request, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word = ep0_decision_t'(out_tdata);
      if (ep0_decisions_due.size() == 0) begin
        report_error($sformatf("result word %0h with no request pending", out_tdata));
      end else begin
        due_word = ep0_decisions_due.pop_front();
        check_field("action", 16'(seen_word.action), 16'(due_word.action));
        check_field("direction_in", 16'(seen_word.direction_in),
                    16'(due_word.direction_in));
        check_field("address_write", 16'(seen_word.address_write),
                    16'(due_word.address_write));
        check_field("device_address", 16'(seen_word.device_address),
                    16'(due_word.device_address));
        check_field("data_source", 16'(seen_word.data_source),
                    16'(due_word.data_source));
        check_field("descriptor_slot", 16'(seen_word.descriptor_slot),
                    16'(due_word.descriptor_slot));
        check_field("reply_byte", 16'(seen_word.reply_byte), 16'(due_word.reply_byte));
        check_field("send_length", seen_word.send_length, due_word.send_length);
        n_checked++;
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, ep0_decisions_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      desc_key[i] = '0;
      desc_len[i] = '0;
      desc_used[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_standard_requests();
    test_descriptor_table();
    test_vendor_requests();
    test_random_phases();
    test_backpressure();
    go_idle();
    $display("summary: %0d setup words and %0d table loads sent, %0d results checked",
             n_setup, n_load, n_checked);
    $display("summary: %0d register writes over 8 settings, %0d mismatches",
             n_cfg, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> usb_standard_request_decoder_unit.f
sv/usd_pkg.sv
sv/usd_desc_table.sv
sv/usb_standard_request_decoder_unit.sv
dv/usb_standard_request_decoder_unit_tb.sv
